// File: hdl/sha1_pkg.sv
// Shared types, initial hash values and round helpers for the SHA-1 engine.
package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef word_t hash_t [5];

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam word_t H0_INIT = 32'h67452301;
    localparam word_t H1_INIT = 32'hEFCDAB89;
    localparam word_t H2_INIT = 32'h98BADCFE;
    localparam word_t H3_INIT = 32'h10325476;
    localparam word_t H4_INIT = 32'hC3D2E1F0;

    localparam word_t K_CH  = 32'h5A827999;
    localparam word_t K_P1  = 32'h6ED9EBA1;
    localparam word_t K_MAJ = 32'h8F1BBCDC;
    localparam word_t K_P2  = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Round constant for round t.
    function automatic word_t round_k(input logic [6:0] t);
        if (t < 7'd20) begin
            round_k = K_CH;
        end else if (t < 7'd40) begin
            round_k = K_P1;
        end else if (t < 7'd60) begin
            round_k = K_MAJ;
        end else begin
            round_k = K_P2;
        end
    endfunction

    // Round function for round t.
    function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                      input word_t c, input word_t d);
        if (t < 7'd20) begin
            round_f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            round_f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

endpackage

// File: hdl/sha1_hash_engine.sv
// SHA-1 digest engine: byte intake, padding sequencer and one shared round unit.
// Steps: a byte item is taken on intake, and when it fills a 64-byte block the engine
// then runs the SHA-1 rounds on the single round adder and one fold step.
// A last item is followed by padding at one byte per cycle, one or two compressions,
// a load of the digest register, plus any wait for that register to free up.
// Reset (aresetn low, synchronous) restores the hash.
module sha1_hash_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_byte_present,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sha1_pkg::word_t      m_digest_h0,
    output sha1_pkg::word_t      m_digest_h1,
    output sha1_pkg::word_t      m_digest_h2,
    output sha1_pkg::word_t      m_digest_h3,
    output sha1_pkg::word_t      m_digest_h4
);
    import sha1_pkg::*;

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

    logic [2:0]  state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [5:0]  pos_reg, pos_next;          // bytes in the current block
    logic [63:0] count_reg, count_next;      // message bytes, wraps
    logic [63:0] len_reg, len_next;          // bit length, shifted out MSB first
    logic        fin_reg, fin_next;          // message ended, padding in progress
    logic        mark_reg, mark_next;        // 0x80 already appended
    logic        lendone_reg, lendone_next;  // length appended, last compression
    word_t       h_reg [5];
    word_t       h_next [5];
    word_t       v_reg [5];
    word_t       v_next [5];
    word_t       w_reg [BLOCK_WORDS];
    word_t       w_next [BLOCK_WORDS];
    logic        m_valid_reg, m_valid_next;
    word_t       dig_reg [5];
    word_t       dig_next [5];

    logic        shift_en;
    logic [7:0]  shift_byte;
    word_t       sched_new;
    word_t       round_sum;
    logic        out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_digest_h0 = dig_reg[0];
    assign m_digest_h1 = dig_reg[1];
    assign m_digest_h2 = dig_reg[2];
    assign m_digest_h3 = dig_reg[3];
    assign m_digest_h4 = dig_reg[4];

    assign out_free = !m_valid_reg || m_ready;

    // Shared round unit: message expansion from the rolling window and one round add.
    assign sched_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign round_sum = rotl(v_reg[0], 5) + round_f(round_reg, v_reg[1], v_reg[2], v_reg[3])
                     + v_reg[4] + w_reg[0] + round_k(round_reg);

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        fin_next     = fin_reg;
        mark_next    = mark_reg;
        lendone_next = lendone_reg;
        h_next       = h_reg;
        v_next       = v_reg;
        w_next       = w_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        shift_en     = 1'b0;
        shift_byte   = 8'h00;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_byte_present) begin
                        shift_en   = 1'b1;
                        shift_byte = s_data_byte;
                        count_next = count_reg + 64'd1;
                    end
                    fin_next = s_last;
                    if (s_byte_present && pos_reg == LAST_POS) begin
                        state_next = ST_ROUND;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!mark_reg) begin
                    shift_en   = 1'b1;
                    shift_byte = PAD_MARK;
                    mark_next  = 1'b1;
                    if (pos_reg == LAST_POS) begin
                        state_next = ST_ROUND;
                    end
                end else if (pos_reg == LEN_POS) begin
                    len_next   = {count_reg[60:0], 3'b000};
                    state_next = ST_LEN;
                end else begin
                    shift_en = 1'b1;
                    if (pos_reg == LAST_POS) begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                shift_byte = len_reg[63:56];
                len_next   = {len_reg[55:0], 8'h00};
                if (pos_reg == LAST_POS) begin
                    lendone_next = 1'b1;
                    state_next   = ST_ROUND;
                end
            end
            ST_ROUND: begin
                v_next[4] = v_reg[3];
                v_next[3] = v_reg[2];
                v_next[2] = rotl(v_reg[1], 30);
                v_next[1] = v_reg[0];
                v_next[0] = round_sum;
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[BLOCK_WORDS - 1] = sched_new;
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < 5; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (lendone_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                // Hold until the digest register is free, then restart the chain.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    dig_next     = h_reg;
                    h_next[0]    = H0_INIT;
                    h_next[1]    = H1_INIT;
                    h_next[2]    = H2_INIT;
                    h_next[3]    = H3_INIT;
                    h_next[4]    = H4_INIT;
                    count_next   = '0;
                    fin_next     = 1'b0;
                    mark_next    = 1'b0;
                    lendone_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte intake: shift the block left by one byte, big-endian packing.
        if (shift_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_next[BLOCK_WORDS - 1] = {w_reg[BLOCK_WORDS - 1][23:0], shift_byte};
            pos_next = pos_reg + 6'd1;
        end

        // Load the working variables whenever a compression starts.
        if (state_reg != ST_ROUND && state_next == ST_ROUND) begin
            v_next = h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            fin_reg     <= 1'b0;
            mark_reg    <= 1'b0;
            lendone_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            h_reg[0]    <= H0_INIT;
            h_reg[1]    <= H1_INIT;
            h_reg[2]    <= H2_INIT;
            h_reg[3]    <= H3_INIT;
            h_reg[4]    <= H4_INIT;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            mark_reg    <= mark_next;
            lendone_reg <= lendone_next;
            m_valid_reg <= m_valid_next;
            h_reg       <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        v_reg   <= v_next;
        w_reg   <= w_next;
        dig_reg <= dig_next;
    end

`ifndef NO_ASSERTIONS
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_FOLD))
        else $error("compression did not fold after the last round");

    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND) |-> (round_reg == 7'd0))
        else $error("round counter nonzero outside compression");

    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> (pos_reg >= LEN_POS && fin_reg && mark_reg))
        else $error("length field placed at wrong block position");

    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("digest not presented after finish");
`endif

endmodule

// File: tb/sv/sha1_hash_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-1 hash engine: random byte messages checked against a built-in digest predictor.
module sha1_hash_engine_tb;
    import sha1_pkg::*;

    // One item as the sender presents it.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       present;
        logic       last;
    } byte_item_t;

    // Five digest words; index 0 holds h0.
    typedef logic [4:0][31:0] digest_t;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned TARGET_ITEMS = 1000;
    localparam int unsigned TARGET_MSGS  = 40;
    localparam int unsigned TAIL_ITEMS   = 120;   // no idling once this few items remain

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic [7:0] s_data_byte    = 8'h00;
    logic       s_byte_present = 1'b0;
    logic       s_last         = 1'b0;
    logic       m_ready        = 1'b0;
    logic       s_ready;
    logic       m_valid;
    word_t      m_digest_h0, m_digest_h1, m_digest_h2, m_digest_h3, m_digest_h4;

    sha1_hash_engine dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_h0    (m_digest_h0),
        .m_digest_h1    (m_digest_h1),
        .m_digest_h2    (m_digest_h2),
        .m_digest_h3    (m_digest_h3),
        .m_digest_h4    (m_digest_h4)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Digest predictor: chaining value, message schedule and byte count.
    // ------------------------------------------------------------------
    word_t       chain_h [5];
    word_t       sched [16];
    logic [63:0] msg_bytes;
    digest_t     digest_q [$];    // digests owed by the engine, oldest first

    // Stimulus bookkeeping.
    byte_item_t  send_q [$];      // items waiting for the driver
    bit          item_on_bus = 1'b0;
    bit          all_queued  = 1'b0;
    int unsigned counted_items = 0;
    int unsigned msgs_queued   = 0;
    int unsigned items_taken   = 0;
    int unsigned bytes_taken   = 0;
    int unsigned digests_ok    = 0;
    int unsigned errors        = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_gap = 0, sink_gap = 0;
    int unsigned src_rate = 0, sink_rate = 0;

    task automatic restart_message();
        chain_h   = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
        msg_bytes = '0;
    endtask

    // Write byte b at block position pos, big-endian within each word.
    task automatic put_byte(input int unsigned pos, input logic [7:0] b);
        int unsigned wi;
        wi = pos / 4;
        if (pos % 4 == 0) begin
            sched[wi] = {b, 24'h000000};
        end else begin
            sched[wi][(3 - pos % 4) * 8 +: 8] = b;
        end
    endtask

    // Run the 80 rounds on the current block and fold into the chaining value.
    task automatic compress_block();
        word_t a, b, c, d, e, w, f, k, t_sum;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w = sched[t];
            end else begin
                w = sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^
                    sched[(t + 2) % 16] ^ sched[t % 16];
                w = {w[30:0], w[31]};
                sched[t % 16] = w;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_P1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_P2;
            end
            t_sum = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t_sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Advance the predictor by one accepted item; a last mark owes a digest.
    task automatic absorb_item(input logic [7:0] data, input logic present, input logic last);
        int unsigned pos;
        logic [63:0] bit_len;
        digest_t     dg;
        if (present) begin
            pos = 32'(msg_bytes[5:0]);
            put_byte(pos, data);
            msg_bytes++;
            if (pos == 63) begin
                compress_block();
            end
        end
        if (last) begin
            // Append the 0x80 marker; spill into an extra block if no room for the length.
            pos = 32'(msg_bytes[5:0]);
            put_byte(pos, PAD_MARK);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    put_byte(pos, 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                put_byte(pos, 8'h00);
                pos++;
            end
            bit_len = msg_bytes << 3;
            for (int i = 0; i < 8; i++) begin
                put_byte(56 + i, bit_len[63 - 8 * i -: 8]);
            end
            compress_block();
            for (int i = 0; i < 5; i++) begin
                dg[i] = chain_h[i];
            end
            digest_q = {digest_q, dg};
            restart_message();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [7:0] data, input logic present, input logic last);
        byte_item_t it;
        it.data_byte = data;
        it.present   = present;
        it.last      = last;
        send_q = {send_q, it};
        if (present || last) begin
            counted_items++;
        end
        if (last) begin
            msgs_queued++;
        end
    endtask

    // Queue one message of len random bytes with occasional no-op items mixed in;
    // the last mark rides on the final byte or comes as a separate byteless item.
    task automatic queue_message(input int unsigned len);
        bit last_on_byte;
        last_on_byte = (len != 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(11) == 0) begin
                queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            queue_item(8'($urandom_range(255)), 1'b1, last_on_byte && (i == len - 1));
        end
        if (!last_on_byte) begin
            queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    // Pick a message length: mostly short, often right at the padding corners.
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(19);
        if (sel < 12) begin
            return $urandom_range(16);
        end else if (sel < 17) begin
            case ($urandom_range(7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(130);
    endfunction

    // Chance, in percent per cycle, of starting an idle burst.
    function automatic int unsigned pick_rate();
        case ($urandom_range(3))
            0: return 0;
            1: return 3;
            2: return 10;
            default: return 30;
        endcase
    endfunction

    function automatic bit quiet_tail();
        return all_queued && (send_q.size() < TAIL_ITEMS);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Driver: predict on each accepted item, then present the next one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        byte_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            restart_message();
            item_on_bus = 1'b0;
            src_gap     = 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(s_data_byte, s_byte_present, s_last);
                item_on_bus = 1'b0;
                items_taken++;
                if (s_byte_present) begin
                    bytes_taken++;
                end
            end
            if (cycle_count % 256 == 0) begin
                src_rate = pick_rate();
            end
            if (s_valid && !s_ready) begin
                // hold the item until it is taken
            end else if (src_gap != 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (send_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(99) < src_rate) begin
                // start an idle burst, this one included
                src_gap = $urandom_range(16);
                s_valid <= 1'b0;
            end else begin
                nxt = send_q.pop_front();
                item_on_bus = 1'b1;
                s_valid        <= 1'b1;
                s_data_byte    <= nxt.data_byte;
                s_byte_present <= nxt.present;
                s_last         <= nxt.last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted digest against the oldest prediction,
    // and stall the result channel in random bursts.
    // ------------------------------------------------------------------
    task automatic check_digest();
        digest_t got, want;
        got = {m_digest_h4, m_digest_h3, m_digest_h2, m_digest_h1, m_digest_h0};
        if (digest_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] unexpected digest %08h %08h %08h %08h %08h", $realtime,
                         got[0], got[1], got[2], got[3], got[4]);
            end
        end else begin
            want = digest_q.pop_front();
            if (got == want) begin
                digests_ok++;
            end
            for (int i = 0; i < 5; i++) begin
                if (got[i] !== want[i]) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("[%0t] digest word h%0d: expected %08h, got %08h",
                                 $realtime, i, want[i], got[i]);
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_digest();
            end
            if (cycle_count % 256 == 128) begin
                sink_rate = pick_rate();
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(99) < sink_rate) begin
                sink_gap = $urandom_range(16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, drain, random messages, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty message, with stray data that must be dropped.
        queue_item(8'hFF, 1'b0, 1'b1);
        // An item with neither byte nor last does nothing.
        queue_item(8'h5A, 1'b0, 1'b0);
        // "abc", last riding on the final byte.
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        // Extreme byte values, an ignored byte between them, last on its own item.
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hA5, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'h3C, 1'b0, 1'b1);
        // One-byte message equal to the pad marker.
        queue_item(8'h80, 1'b1, 1'b1);
        // Back-to-back empty messages.
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);

        // Hold the sender until every digest owed so far has come back.
        while (send_q.size() != 0 || item_on_bus || digest_q.size() != 0) begin
            @(posedge aclk);
        end

        while (counted_items < TARGET_ITEMS || msgs_queued < TARGET_MSGS) begin
            queue_message(pick_length());
        end
        all_queued = 1'b1;

        while (send_q.size() != 0 || item_on_bus || digest_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (digest_q.size() != 0) begin
            errors += digest_q.size();
            $display("%0d digests never arrived", digest_q.size());
        end
        $display("Run covered %0d items (%0d message bytes) over %0d messages;",
                 items_taken, bytes_taken, msgs_queued);
        $display("%0d digests matched, %0d mismatches, %0d cycles",
                 digests_ok, errors, cycle_count);
        if (errors == 0) begin
            $display("PASS sha1_hash_engine");
        end else begin
            $display("FAIL sha1_hash_engine");
        end
        $finish;
    end

    // Watchdog: end the run if it hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles with %0d digests outstanding",
                 CYCLE_LIMIT, digest_q.size());
        $display("FAIL sha1_hash_engine");
        $finish;
    end

endmodule
